[hdl/round_robin_run_queue_core_defines.svh]
// ----------------------------------------------------------------------------
// Round-robin run queue assertion macros
// Property check helpers for simulation; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_RUN_QUEUE_CORE_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RRRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define RRRQ_ASSERT(label, clk, rst_n, prop, msg)
`define RRRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/rrrq_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin run queue package
// Field widths, operation codes, state codes and control structures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrrq_pkg;

    localparam int OP_W        = 2;
    localparam int ID_W        = 6;
    localparam int CNT_W       = 7;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int ID_SPAN     = 2 ** ID_W;
    localparam int THREADS_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_POP,
        S_UNLINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic append;
        logic append_run;
        logic clr_nrq;
        logic set_nrq;
        logic read_links;
        logic read_head;
        logic unlink;
        logic clear_run;
        logic set_run;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic id_ok;
        logic req_running;
        logic req_queued;
        logic run_requeue;
        logic queue_empty;
        logic out_busy;
    } t_status;

endpackage

[hdl/rrrq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrrq_ram #(
    parameter int WIDTH = rrrq_pkg::ID_W,
    parameter int DEPTH = rrrq_pkg::THREADS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rrrq_ctrl.sv]
// ----------------------------------------------------------------------------
// Round-robin run queue controller
// Sequences each item through decode, link read, unlink and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrrq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rrrq_pkg::t_status i_status,
    output rrrq_pkg::t_cmd    o_cmd
);

    rrrq_pkg::t_state r_state;
    rrrq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrrq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rrrq_pkg::S_DECODE;
                end
            end
            rrrq_pkg::S_DECODE: begin
                n_state = rrrq_pkg::S_DONE;
                case (i_status.op)
                    rrrq_pkg::OP_DEQUEUE: begin
                        if (i_status.id_ok && !i_status.req_running && i_status.req_queued) begin
                            n_state = rrrq_pkg::S_UNLINK;
                        end
                    end
                    rrrq_pkg::OP_TICK: begin
                        n_state = rrrq_pkg::S_TICK_POP;
                    end
                    default: begin
                        n_state = rrrq_pkg::S_DONE;
                    end
                endcase
            end
            rrrq_pkg::S_TICK_POP: begin
                n_state = i_status.queue_empty ? rrrq_pkg::S_DONE : rrrq_pkg::S_UNLINK;
            end
            rrrq_pkg::S_UNLINK: begin
                n_state = rrrq_pkg::S_DONE;
            end
            rrrq_pkg::S_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = rrrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrrq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rrrq_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            rrrq_pkg::S_DECODE: begin
                case (i_status.op)
                    rrrq_pkg::OP_ENQUEUE: begin
                        if (i_status.id_ok) begin
                            o_cmd.clr_nrq = i_status.req_running || !i_status.req_queued;
                            o_cmd.append  = !i_status.req_running && !i_status.req_queued;
                        end
                    end
                    rrrq_pkg::OP_DEQUEUE: begin
                        if (i_status.id_ok) begin
                            o_cmd.set_nrq    = i_status.req_running;
                            o_cmd.read_links = !i_status.req_running && i_status.req_queued;
                        end
                    end
                    rrrq_pkg::OP_TICK: begin
                        o_cmd.append     = i_status.run_requeue;
                        o_cmd.append_run = i_status.run_requeue;
                        o_cmd.clear_run  = 1'b1;
                    end
                    default: begin
                        o_cmd = '0;
                    end
                endcase
            end
            rrrq_pkg::S_TICK_POP: begin
                o_cmd.read_links = !i_status.queue_empty;
                o_cmd.read_head  = !i_status.queue_empty;
            end
            rrrq_pkg::S_UNLINK: begin
                o_cmd.unlink  = 1'b1;
                o_cmd.set_run = (i_status.op == rrrq_pkg::OP_TICK);
            end
            rrrq_pkg::S_DONE: begin
                o_cmd.load_out = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[hdl/rrrq_dpath.sv]
// ----------------------------------------------------------------------------
// Round-robin run queue datapath
// Link memories, queue marks, head and tail pointers, running thread and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_run_queue_core_defines.svh"

module rrrq_dpath #(
    parameter int THREADS = rrrq_pkg::THREADS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rrrq_pkg::t_cmd                    i_cmd,
    input  logic [rrrq_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_out_ready,
    output rrrq_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    output logic [rrrq_pkg::OUT_DATA_W-1:0]   o_out_data
);

    localparam int SLOTS = (THREADS < rrrq_pkg::ID_SPAN) ? THREADS : rrrq_pkg::ID_SPAN;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    logic [rrrq_pkg::OP_W-1:0] r_op;
    logic [IW-1:0]             r_id;
    logic                      r_id_ok;
    logic [IW-1:0]             r_victim;
    logic [IW-1:0]             r_head;
    logic [IW-1:0]             n_head;
    logic [IW-1:0]             r_tail;
    logic [IW-1:0]             n_tail;
    logic [CW-1:0]             r_len;
    logic [CW-1:0]             n_len;
    logic [IW-1:0]             r_run_id;
    logic [IW-1:0]             n_run_id;
    logic                      r_run_flag;
    logic                      n_run_flag;
    logic [SLOTS-1:0]          r_queued;
    logic [SLOTS-1:0]          r_nrq;
    logic                      r_out_valid;
    logic [rrrq_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [rrrq_pkg::ID_W-1:0] in_id;
    logic [IW-1:0]             app_id;
    logic [IW-1:0]             rd_addr;
    logic [IW-1:0]             next_rd;
    logic [IW-1:0]             prev_rd;
    logic                      next_we;
    logic [IW-1:0]             next_waddr;
    logic [IW-1:0]             next_wdata;
    logic                      prev_we;
    logic [IW-1:0]             prev_waddr;
    logic [IW-1:0]             prev_wdata;
    logic                      is_head;
    logic                      is_tail;

    assign in_id   = i_in_data[rrrq_pkg::OP_W +: rrrq_pkg::ID_W];
    assign app_id  = i_cmd.append_run ? r_run_id : r_id;
    assign rd_addr = i_cmd.read_head ? r_head : r_id;
    assign is_head = (r_victim == r_head);
    assign is_tail = (r_victim == r_tail);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data[rrrq_pkg::OP_W-1:0];
            r_id    <= IW'(in_id);
            r_id_ok <= (int'(in_id) < THREADS);
        end
        if (i_cmd.read_links) begin
            r_victim <= rd_addr;
        end
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_run_id   = r_run_id;
        n_run_flag = r_run_flag;
        next_we    = 1'b0;
        next_waddr = r_tail;
        next_wdata = app_id;
        prev_we    = 1'b0;
        prev_waddr = app_id;
        prev_wdata = r_tail;
        if (i_cmd.append) begin
            if (r_len == '0) begin
                n_head = app_id;
            end else begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            n_tail = app_id;
            n_len  = r_len + CW'(1);
        end
        if (i_cmd.unlink) begin
            if (is_head && is_tail) begin
                n_head = '0;
                n_tail = '0;
            end else if (is_head) begin
                n_head = next_rd;
            end else if (is_tail) begin
                n_tail = prev_rd;
            end else begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_we    = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
            if (r_len != '0) begin
                n_len = r_len - CW'(1);
            end
        end
        if (i_cmd.clear_run) begin
            n_run_id   = '0;
            n_run_flag = 1'b0;
        end
        if (i_cmd.set_run) begin
            n_run_id   = r_victim;
            n_run_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_len      <= '0;
            r_run_id   <= '0;
            r_run_flag <= 1'b0;
            r_queued   <= '0;
            r_nrq      <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_len      <= n_len;
            r_run_id   <= n_run_id;
            r_run_flag <= n_run_flag;
            if (i_cmd.append) begin
                r_queued[app_id] <= 1'b1;
            end
            if (i_cmd.unlink) begin
                r_queued[r_victim] <= 1'b0;
            end
            if (i_cmd.clr_nrq) begin
                r_nrq[r_id] <= 1'b0;
            end
            if (i_cmd.set_nrq) begin
                r_nrq[r_id] <= 1'b1;
            end
        end
    end

    rrrq_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (rd_addr),
        .o_rdata (next_rd)
    );

    rrrq_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (rd_addr),
        .o_rdata (prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{(rrrq_pkg::OUT_DATA_W - rrrq_pkg::CNT_W - 1 - rrrq_pkg::ID_W){1'b0}},
                           rrrq_pkg::CNT_W'(r_len), r_run_flag, rrrq_pkg::ID_W'(r_run_id)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_status             = '0;
        o_status.op          = rrrq_pkg::t_op'(r_op);
        o_status.id_ok       = r_id_ok;
        o_status.req_running = r_run_flag && (r_id == r_run_id);
        o_status.req_queued  = r_queued[r_id];
        o_status.run_requeue = r_run_flag && !r_nrq[r_run_id] && !r_queued[r_run_id];
        o_status.queue_empty = (r_len == '0);
        o_status.out_busy    = r_out_valid && !i_out_ready;
    end

    `RRRQ_ASSERT(a_len_matches_marks, i_clk, i_rst_n, ($countones(r_queued) == int'(r_len)), "queue length differs from number of queued marks")
    `RRRQ_ASSERT(a_running_not_queued, i_clk, i_rst_n, (r_run_flag |-> !r_queued[r_run_id]), "running thread is also in the ready queue")
    `RRRQ_ASSERT(a_unlink_queued, i_clk, i_rst_n, (i_cmd.unlink |-> r_queued[r_victim]), "unlink of a thread that is not queued")
    `RRRQ_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, i_cmd.append, (r_len == CW'($past(r_len) + CW'(1))), "append did not grow the queue by one")

endmodule

[hdl/round_robin_run_queue_core.sv]
// ----------------------------------------------------------------------------
// Round-robin run queue core
// Ready queue of thread ids kept as a doubly linked list, with one running
// thread and a reschedule tick.
// ----------------------------------------------------------------------------
// Each input item returns exactly one result item with the state after the
// operation. An enqueue goes through decode and result load; a dequeue that
// removes a waiting thread adds the unlink, and a reschedule tick that starts
// a new thread adds a head pop and the unlink: the registered read of the
// link memories followed by the unlink write-back. A new item is taken while
// the previous result still waits in the output register. Only thread ids
// below THREADS (and below 64) take effect; others return the state.
`timescale 1ns / 1ps

module round_robin_run_queue_core #(
    parameter int THREADS = rrrq_pkg::THREADS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // operation [1:0], thread_id [7:2]
    input  logic [rrrq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // running_id [5:0], running_valid [6], waiting_count [13:7], zero [15:14]
    output logic [rrrq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    rrrq_pkg::t_cmd    cmd;
    rrrq_pkg::t_status status;

    rrrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrrq_dpath #(
        .THREADS (THREADS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
